>>> hw/rtl/owr_pkg.sv
// ----------------------------------------------------------------------------
// owr_pkg
// shared types, point kind codes and grid snapping for the wire router
// ----------------------------------------------------------------------------
package owr_pkg;

    localparam logic [1:0] KIND_PIN    = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;
    localparam logic [1:0] KIND_BEND   = 2'd3;

    localparam logic [15:0] GRID_STEP  = 16'd20;
    // ceil(2^20 / 20), exact quotient for magnitudes up to 2^15
    localparam logic [16:0] GRID_RECIP = 17'd52429;

    localparam logic [1:0] IDX_START = 2'd0;
    localparam logic [1:0] IDX_BEND1 = 2'd1;
    localparam logic [1:0] IDX_BEND2 = 2'd2;
    localparam logic [1:0] IDX_END   = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         kind;
    } point_t;

    typedef struct packed {
        point_t start_pt;
        point_t end_pt;
    } request_t;

    typedef struct packed {
        point_t start_pt;
        point_t bend1;
        point_t bend2;
        point_t end_pt;
        logic   bend1_vld;
        logic   bend2_vld;
    } route_t;

    // halve with truncation toward zero
    function automatic logic signed [16:0] half_toward_zero(logic signed [16:0] d);
        logic signed [16:0] h;
        h = d >>> 1;
        if (d[16] && d[0]) begin
            h = h + 17'sd1;
        end
        return h;
    endfunction

    // (v / 20) * 20 with truncation toward zero
    function automatic logic signed [15:0] snap_grid(logic signed [15:0] v);
        logic [16:0] mag;
        logic [33:0] prod;
        logic [10:0] quo;
        logic [15:0] base;
        mag  = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        prod = 34'(mag) * 34'(GRID_RECIP);
        quo  = prod[30:20];
        base = 16'(quo) * GRID_STEP;
        return v[15] ? $signed(16'd0 - base) : $signed(base);
    endfunction

endpackage

>>> hw/rtl/owr_route_calc.sv
// ----------------------------------------------------------------------------
// owr_route_calc
// picks the layout from the endpoint kinds and computes the bend points
// ----------------------------------------------------------------------------
module owr_route_calc
    import owr_pkg::*;
(
    input  request_t req,
    output route_t   route
);

    typedef enum logic [2:0] {
        LAYOUT_BB,
        LAYOUT_PP,
        LAYOUT_BP,
        LAYOUT_PB,
        LAYOUT_FB
    } layout_t;

    logic signed [15:0] sx, sy, ex, ey;
    logic [1:0]         sk, ek, es, ee;
    logic               same_pt;
    layout_t            layout;
    logic signed [16:0] mid_bb, mid_pp, mid_fb;
    logic signed [15:0] snap_in, snap_out;

    assign sx = req.start_pt.x;
    assign sy = req.start_pt.y;
    assign sk = req.start_pt.kind;
    assign ex = req.end_pt.x;
    assign ey = req.end_pt.y;
    assign ek = req.end_pt.kind;

    assign same_pt = (sx == ex) && (sy == ey);

    // a free endpoint becomes a pin opposite a pin or a free end, else a branch
    always_comb begin
        es = sk;
        ee = ek;
        if (sk == KIND_FREE && ek == KIND_FREE) begin
            es = KIND_PIN;
            ee = KIND_PIN;
        end else if (sk == KIND_FREE) begin
            es = (ek == KIND_PIN) ? KIND_PIN : KIND_BRANCH;
        end else if (ek == KIND_FREE) begin
            ee = (sk == KIND_PIN) ? KIND_PIN : KIND_BRANCH;
        end
    end

    always_comb begin
        if (es == KIND_BRANCH && ee == KIND_BRANCH) begin
            layout = LAYOUT_BB;
        end else if (es == KIND_PIN && ee == KIND_PIN) begin
            layout = LAYOUT_PP;
        end else if (es == KIND_BRANCH && ee == KIND_PIN) begin
            layout = LAYOUT_BP;
        end else if (es == KIND_PIN && ee == KIND_BRANCH) begin
            layout = LAYOUT_PB;
        end else begin
            layout = LAYOUT_FB;
        end
    end

    assign mid_bb = {sy[15], sy} + half_toward_zero({ey[15], ey} - {sy[15], sy});
    assign mid_pp = {sx[15], sx} + half_toward_zero({ex[15], ex} - {sx[15], sx});
    assign mid_fb = half_toward_zero({sx[15], sx} + {ex[15], ex});

    always_comb begin
        case (layout)
            LAYOUT_BB: snap_in = mid_bb[15:0];
            LAYOUT_PP: snap_in = mid_pp[15:0];
            LAYOUT_BP: snap_in = ey;
            LAYOUT_PB: snap_in = ex;
            default:   snap_in = mid_fb[15:0];
        endcase
    end

    assign snap_out = snap_grid(snap_in);

    always_comb begin
        route.start_pt   = req.start_pt;
        route.end_pt     = req.end_pt;
        route.bend1.kind = KIND_BEND;
        route.bend2.kind = KIND_BEND;
        route.bend1.x    = snap_out;
        route.bend1.y    = sy;
        route.bend2.x    = snap_out;
        route.bend2.y    = ey;
        route.bend1_vld  = 1'b0;
        route.bend2_vld  = 1'b0;
        case (layout)
            LAYOUT_BB: begin
                route.bend1.x   = sx;
                route.bend1.y   = snap_out;
                route.bend2.x   = ex;
                route.bend2.y   = snap_out;
                route.bend1_vld = (snap_out != sy);
                route.bend2_vld = (ex != sx);
            end
            LAYOUT_PP: begin
                route.bend1_vld = (snap_out != sx);
                route.bend2_vld = (ey != sy);
            end
            LAYOUT_BP: begin
                route.bend1.x   = sx;
                route.bend1.y   = snap_out;
                route.bend1_vld = (snap_out != sy) && !((sx == ex) && (snap_out == ey));
            end
            LAYOUT_PB: begin
                route.bend1_vld = (snap_out != sx) && !((snap_out == ex) && (sy == ey));
            end
            default: begin
                route.bend1_vld = (snap_out != sx);
                route.bend2_vld = (snap_out != ex);
            end
        endcase
        if (same_pt) begin
            route.bend1_vld = 1'b0;
            route.bend2_vld = 1'b0;
        end
    end

endmodule

>>> hw/rtl/owr_point_emitter.sv
// ----------------------------------------------------------------------------
// owr_point_emitter
// holds one computed route; sends one point per cycle while m_ready is high
// ----------------------------------------------------------------------------
module owr_point_emitter
    import owr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_valid,
    output logic                load_ready,
    input  route_t              load_route,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_point_x,
    output logic signed [15:0]  m_point_y,
    output logic [1:0]          m_point_kind,
    output logic                m_last_point
);

    route_t     route_reg;
    logic       full_reg, full_next;
    logic [1:0] idx_reg, idx_next;
    logic       take, finish, load;
    point_t     cur_pt;

    assign take       = full_reg && m_ready;
    assign finish     = take && (idx_reg == IDX_END);
    assign load_ready = !full_reg || finish;
    assign load       = load_valid && load_ready;

    always_comb begin
        case (idx_reg)
            IDX_START: cur_pt = route_reg.start_pt;
            IDX_BEND1: cur_pt = route_reg.bend1;
            IDX_BEND2: cur_pt = route_reg.bend2;
            default:   cur_pt = route_reg.end_pt;
        endcase
    end

    assign m_valid      = full_reg;
    assign m_point_x    = cur_pt.x;
    assign m_point_y    = cur_pt.y;
    assign m_point_kind = cur_pt.kind;
    assign m_last_point = (idx_reg == IDX_END);

    always_comb begin
        full_next = full_reg;
        idx_next  = idx_reg;
        if (load) begin
            full_next = 1'b1;
            idx_next  = IDX_START;
        end else if (finish) begin
            full_next = 1'b0;
        end else if (take) begin
            case (idx_reg)
                IDX_START: begin
                    if (route_reg.bend1_vld) begin
                        idx_next = IDX_BEND1;
                    end else if (route_reg.bend2_vld) begin
                        idx_next = IDX_BEND2;
                    end else begin
                        idx_next = IDX_END;
                    end
                end
                IDX_BEND1: idx_next = route_reg.bend2_vld ? IDX_BEND2 : IDX_END;
                default:   idx_next = IDX_END;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
            idx_reg  <= IDX_START;
        end else begin
            full_reg <= full_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            route_reg <= load_route;
        end
    end

    // a skipped bend is never shown
    a_bend1_shown_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg && (idx_reg == IDX_BEND1) |-> route_reg.bend1_vld)
        else $error("bend1 shown without being valid");

    a_bend2_shown_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg && (idx_reg == IDX_BEND2) |-> route_reg.bend2_vld)
        else $error("bend2 shown without being valid");

    // a route is held until its last point goes out
    a_route_held: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg && !finish |=> full_reg && $stable(route_reg))
        else $error("route changed before its end point was taken");

    // a taken non-final point advances the index
    a_index_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !finish |=> idx_reg > $past(idx_reg))
        else $error("point index did not advance");

    a_load_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> full_reg && (idx_reg == IDX_START))
        else $error("new route does not start at its first point");

endmodule

>>> hw/rtl/orthogonal_wire_router.sv
// ----------------------------------------------------------------------------
// orthogonal_wire_router
// manhattan route between two endpoints as a run of two to four points
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    start_x/y/kind, end_x/y/kind
//  m_       out  m_valid/m_ready    point_x/y/kind, last_point
//
//  a request sits in the input register, its route is computed in one pass
//  into the route register, and the points leave one per cycle from there
//  while m_ready is high; a request gives two to four points on the output
//  the next request is taken while the current route is still being sent
//  reset (aresetn low, synchronous) empties both registers
//  a stalled m_ready holds the current point and backs up into s_ready
// ----------------------------------------------------------------------------
module orthogonal_wire_router
    import owr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_start_x,
    input  logic signed [15:0]  s_start_y,
    input  logic [1:0]          s_start_kind,
    input  logic signed [15:0]  s_end_x,
    input  logic signed [15:0]  s_end_y,
    input  logic [1:0]          s_end_kind,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_point_x,
    output logic signed [15:0]  m_point_y,
    output logic [1:0]          m_point_kind,
    output logic                m_last_point
);

    request_t req_reg;
    logic     req_full_reg, req_full_next;
    logic     load_ready;
    route_t   route;

    assign s_ready = !req_full_reg || load_ready;

    always_comb begin
        req_full_next = req_full_reg;
        if (s_valid && s_ready) begin
            req_full_next = 1'b1;
        end else if (load_ready) begin
            req_full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_full_reg <= 1'b0;
        end else begin
            req_full_reg <= req_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.start_pt.x    <= s_start_x;
            req_reg.start_pt.y    <= s_start_y;
            req_reg.start_pt.kind <= s_start_kind;
            req_reg.end_pt.x      <= s_end_x;
            req_reg.end_pt.y      <= s_end_y;
            req_reg.end_pt.kind   <= s_end_kind;
        end
    end

    owr_route_calc u_calc (
        .req   (req_reg),
        .route (route)
    );

    owr_point_emitter u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_valid   (req_full_reg),
        .load_ready   (load_ready),
        .load_route   (route),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_kind (m_point_kind),
        .m_last_point (m_last_point)
    );

endmodule

>>> bench/orthogonal_wire_router_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthogonal_wire_router_tb
// self-checking bench for the orthogonal wire router: directed endpoint pairs
// cover every kind pair, coordinate extremes and dropped bends, then random
// pairs near and far apart; each accepted request is routed by a local
// predictor and every emitted point is checked in order against it, with
// random idle gaps on both channels and one long output stall
// ----------------------------------------------------------------------------
module orthogonal_wire_router_tb;
    import owr_pkg::*;

    localparam int RANDOM_REQUESTS = 385;
    localparam int IDLE_LIMIT      = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int MAX_PRINTS      = 50;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         kind;
        logic               last;
    } route_point_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_start_x = '0;
    logic signed [15:0] s_start_y = '0;
    logic [1:0]         s_start_kind = KIND_PIN;
    logic signed [15:0] s_end_x = '0;
    logic signed [15:0] s_end_y = '0;
    logic [1:0]         s_end_kind = KIND_PIN;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_point_x;
    logic signed [15:0] m_point_y;
    logic [1:0]         m_point_kind;
    logic               m_last_point;

    request_t     pending_requests[$];
    route_point_t expected_points[$];
    request_t     cur_request;
    int           n_requests;
    int           n_requests_done = 0;
    int           n_points_seen = 0;
    int           n_errors = 0;
    int           send_wait = 0;
    int           recv_wait = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    bit           offering;
    int           idle_cycles = 0;

    orthogonal_wire_router dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_start_kind (s_start_kind),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_end_kind   (s_end_kind),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_kind (m_point_kind),
        .m_last_point (m_last_point)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int grid_snap(int v);
        return (v / int'(GRID_STEP)) * int'(GRID_STEP);
    endfunction

    function automatic void push_point(int x, int y, logic [1:0] kind, logic last);
        route_point_t p;
        p.x    = 16'(x);
        p.y    = 16'(y);
        p.kind = kind;
        p.last = last;
        expected_points = {expected_points, p};
    endfunction

    function automatic void route_predict(request_t r);
        int         sx, sy, ex, ey, m;
        logic [1:0] sk, ek, es, ee;
        sx = int'($signed(r.start_pt.x));
        sy = int'($signed(r.start_pt.y));
        ex = int'($signed(r.end_pt.x));
        ey = int'($signed(r.end_pt.y));
        sk = r.start_pt.kind;
        ek = r.end_pt.kind;
        push_point(sx, sy, sk, 1'b0);
        if (sx == ex && sy == ey) begin
            push_point(ex, ey, ek, 1'b1);
            return;
        end
        es = sk;
        ee = ek;
        if (sk == KIND_FREE && ek == KIND_FREE) begin
            es = KIND_PIN;
            ee = KIND_PIN;
        end else if (sk == KIND_FREE) begin
            es = (ek == KIND_PIN) ? KIND_PIN : KIND_BRANCH;
        end else if (ek == KIND_FREE) begin
            ee = (sk == KIND_PIN) ? KIND_PIN : KIND_BRANCH;
        end
        if (es == KIND_BRANCH && ee == KIND_BRANCH) begin
            m = grid_snap(sy + (ey - sy) / 2);
            if (m != sy) push_point(sx, m, KIND_BEND, 1'b0);
            if (ex != sx) push_point(ex, m, KIND_BEND, 1'b0);
        end else if (es == KIND_PIN && ee == KIND_PIN) begin
            m = grid_snap(sx + (ex - sx) / 2);
            if (m != sx) push_point(m, sy, KIND_BEND, 1'b0);
            if (ey != sy) push_point(m, ey, KIND_BEND, 1'b0);
        end else if (es == KIND_BRANCH && ee == KIND_PIN) begin
            m = grid_snap(ey);
            if (m != sy && !(sx == ex && m == ey)) push_point(sx, m, KIND_BEND, 1'b0);
        end else if (es == KIND_PIN && ee == KIND_BRANCH) begin
            m = grid_snap(ex);
            if (m != sx && !(m == ex && sy == ey)) push_point(m, sy, KIND_BEND, 1'b0);
        end else begin
            m = grid_snap((sx + ex) / 2);
            if (m != sx) push_point(m, sy, KIND_BEND, 1'b0);
            if (m != ex) push_point(m, ey, KIND_BEND, 1'b0);
        end
        push_point(ex, ey, ek, 1'b1);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (n_errors < MAX_PRINTS) begin
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
        end
        n_errors++;
    endtask

    task automatic add_request(int sx, int sy, logic [1:0] sk, int ex, int ey,
                               logic [1:0] ek);
        request_t r;
        r.start_pt.x    = 16'(sx);
        r.start_pt.y    = 16'(sy);
        r.start_pt.kind = sk;
        r.end_pt.x      = 16'(ex);
        r.end_pt.y      = 16'(ey);
        r.end_pt.kind   = ek;
        pending_requests = {pending_requests, r};
    endtask

    function automatic int rand_coord();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0, 1: return int'($signed(16'($urandom)));
            2: return int'($urandom_range(0, 400)) - 200;
            3: return 20 * (int'($urandom_range(0, 20)) - 10);
            default: begin
                case ($urandom_range(0, 3))
                    0: return -32768;
                    1: return 32767;
                    2: return -32767;
                    default: return 0;
                endcase
            end
        endcase
    endfunction

    function automatic int near_coord(int v);
        return int'($signed(16'(v + int'($urandom_range(0, 300)) - 150)));
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = $urandom_range(0, 14);
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                route_predict(cur_request);
                n_requests_done++;
                offering = 1'b0;
                send_wait = ((n_requests_done / 60) % 3 == 1) ? 0 : $urandom_range(0, 14);
            end
            if (!offering) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    cur_request = pending_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_start_x    <= cur_request.start_pt.x;
                    s_start_y    <= cur_request.start_pt.y;
                    s_start_kind <= cur_request.start_pt.kind;
                    s_end_x      <= cur_request.end_pt.x;
                    s_end_y      <= cur_request.end_pt.y;
                    s_end_kind   <= cur_request.end_pt.kind;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // route point monitor
    always @(posedge aclk) begin
        route_point_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_points_seen++;
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected point_x", m_point_x, 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_point_x !== want.x) report_mismatch("point_x", m_point_x, want.x);
                    if (m_point_y !== want.y) report_mismatch("point_y", m_point_y, want.y);
                    if (m_point_kind !== want.kind) begin
                        report_mismatch("point_kind", m_point_kind, want.kind);
                    end
                    if (m_last_point !== want.last) begin
                        report_mismatch("last_point", m_last_point, want.last);
                    end
                end
                recv_wait = ((n_points_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 14);
                // one long stall so the input side backs up
                if (!hold_done && n_points_seen >= 120) begin
                    hold_left = LONG_HOLD;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int sx, sy, ex, ey;

        // equal endpoints
        add_request(0, 0, KIND_PIN, 0, 0, KIND_PIN);
        add_request(-32768, 32767, KIND_BEND, -32768, 32767, KIND_FREE);
        // every kind pair, negative y midpoints
        for (int sk = KIND_PIN; sk <= KIND_BEND; sk++) begin
            for (int ek = KIND_PIN; ek <= KIND_BEND; ek++) begin
                add_request(-35 + 7 * sk, 17, 2'(sk), 47, -93 + 11 * ek, 2'(ek));
            end
        end
        // coordinate extremes
        add_request(-32768, -32768, KIND_BRANCH, 32767, 32767, KIND_BRANCH);
        add_request(32767, -32768, KIND_PIN, -32768, 32767, KIND_PIN);
        // bends dropped where they meet another point of the route
        add_request(100, 0, KIND_BRANCH, 100, 55, KIND_BRANCH);
        add_request(0, 0, KIND_BRANCH, 50, 10, KIND_BRANCH);
        add_request(0, 0, KIND_PIN, 10, 50, KIND_PIN);
        add_request(40, 0, KIND_BRANCH, 40, 60, KIND_PIN);
        add_request(40, 10, KIND_PIN, 45, 90, KIND_BRANCH);
        add_request(0, 0, KIND_BEND, 0, 5, KIND_BEND);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            sx = rand_coord();
            sy = rand_coord();
            case ($urandom_range(0, 7))
                0: begin
                    ex = sx;
                    ey = sy;
                end
                1: begin
                    ex = sx;
                    ey = near_coord(sy);
                end
                2: begin
                    ex = near_coord(sx);
                    ey = sy;
                end
                3, 4: begin
                    ex = near_coord(sx);
                    ey = near_coord(sy);
                end
                default: begin
                    ex = rand_coord();
                    ey = rand_coord();
                end
            endcase
            add_request(sx, sy, 2'($urandom), ex, ey, 2'($urandom));
        end
        n_requests = pending_requests.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_requests_done < n_requests || expected_points.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/owr_pkg.sv
hw/rtl/owr_route_calc.sv
hw/rtl/owr_point_emitter.sv
hw/rtl/orthogonal_wire_router.sv
bench/orthogonal_wire_router_tb.sv
